// ===== rtl/cps_pkg.sv =====
package cps_pkg;

	// sizing
	localparam int MAX_POINTS = 64;
	localparam int MAX_DIM    = 8;
	localparam int COORD_W    = 16;

	localparam int DEPTH   = MAX_POINTS * MAX_DIM;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int BASE_W  = CNT_W + 1;
	localparam int IDX_W   = $clog2(MAX_POINTS);
	localparam int NP_W    = $clog2(MAX_POINTS + 2);
	localparam int K_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int SQ_W    = 2 * COORD_W;

	// fixed field widths
	localparam int DIM_W   = 4;
	localparam int DIST_W  = 35;

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_ERR,
		S_SCAN,
		S_DRAIN,
		S_LEX,
		S_LDRAIN
	} cps_state_t;

	typedef struct packed {
		logic load;       // store accepted coordinate
		logic chk_init;   // final coordinate accepted: start point count
		logic chk_step;
		logic clr;        // clear coordinate count and overflow
		logic scan_init;
		logic scan_step;
		logic lex_init;
		logic lex_step;
		logic res_load;
		logic res_err;
	} cps_cmd_t;

	typedef struct packed {
		logic chk_bad;
		logic chk_match;
		logic chk_few;
		logic scan_final;
		logic k_last;
		logic pipe_busy;
		logic out_free;
	} cps_sts_t;

endpackage

// ===== rtl/closest_pair_search.sv =====
// Closest pair search: coordinates stream in one per cycle (dim_count per point, in point
// order, last on the final coordinate of the set) and go into a 512-entry store; up to 64
// points of up to 8 dimensions. After last the block stalls its input and works on the set:
// a point count, then a scan of every pair i<j that reads one coordinate pair per cycle
// through the store's two read ports, a drain of the square-and-add pipeline, and an
// ordering of the chosen pair lexicographically. One request comes out per set: the two
// indices (lexicographically smaller point first, index order if the points are equal),
// the squared distance, and error, which flags fewer than two points, more than 64 points,
// store overflow, a partial point or a bad dim_count, with all other fields zero. Equal
// distances go to the later pair.
// Loading of the next set proceeds while the result waits on out_stall.
module closest_pair_search (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [cps_pkg::DIM_W-1:0]          cfg_data,
	// coordinate requests
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [cps_pkg::COORD_W-1:0] coord,
	input  logic                               last,
	// result requests
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [5:0]                         first_index,
	output logic [5:0]                         second_index,
	output logic [cps_pkg::DIST_W-1:0]         min_distance,
	output logic                               error
);

	cps_pkg::cps_cmd_t cmd;
	cps_pkg::cps_sts_t sts;

	// sequencing: load, count, scan, drain, order, emit, or emit an error
	cps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, distance pipeline, best pair tracking and result register
	cps_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.coord        (coord),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_index  (first_index),
		.second_index (second_index),
		.min_distance (min_distance),
		.error        (error)
	);

endmodule

// ===== rtl/cps_ctrl.sv =====
module cps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last,
	output logic              in_stall,
	input  cps_pkg::cps_sts_t sts,
	output cps_pkg::cps_cmd_t cmd
);

	cps_pkg::cps_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cps_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			cps_pkg::S_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last) begin
						cmd.chk_init = 1'b1;
						state_d      = cps_pkg::S_CHECK;
					end
				end
			end
			cps_pkg::S_CHECK: begin
				if (sts.chk_bad || (sts.chk_match && sts.chk_few)) begin
					cmd.clr = 1'b1;
					state_d = cps_pkg::S_ERR;
				end else if (sts.chk_match) begin
					cmd.clr       = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = cps_pkg::S_SCAN;
				end else begin
					cmd.chk_step = 1'b1;
				end
			end
			cps_pkg::S_ERR: begin
				if (sts.out_free) begin
					cmd.res_err = 1'b1;
					state_d     = cps_pkg::S_LOAD;
				end
			end
			cps_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_final) begin
					state_d = cps_pkg::S_DRAIN;
				end
			end
			cps_pkg::S_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.lex_init = 1'b1;
					state_d      = cps_pkg::S_LEX;
				end
			end
			cps_pkg::S_LEX: begin
				cmd.lex_step = 1'b1;
				if (sts.k_last) begin
					state_d = cps_pkg::S_LDRAIN;
				end
			end
			cps_pkg::S_LDRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = cps_pkg::S_LOAD;
				end
			end
			default: begin
				state_d = cps_pkg::S_LOAD;
			end
		endcase
	end

endmodule

// ===== rtl/cps_dp.sv =====
module cps_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cps_pkg::DIM_W-1:0]         cfg_data,
	input  logic signed [cps_pkg::COORD_W-1:0] coord,
	input  cps_pkg::cps_cmd_t                 cmd,
	output cps_pkg::cps_sts_t                 sts,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [5:0]                        first_index,
	output logic [5:0]                        second_index,
	output logic [cps_pkg::DIST_W-1:0]        min_distance,
	output logic                              error
);

	// coordinate store
	logic signed [cps_pkg::COORD_W-1:0] mem [cps_pkg::DEPTH];

	logic [cps_pkg::DIM_W-1:0]  dim_q;
	logic [cps_pkg::CNT_W-1:0]  cnt_q;
	logic                       ovf_q;
	logic [cps_pkg::BASE_W-1:0] base_q;
	logic [cps_pkg::NP_W-1:0]   np_q;

	// scan position
	logic [cps_pkg::IDX_W-1:0]  i_q, j_q;
	logic [cps_pkg::ADDR_W-1:0] bi_q, bj_q;
	logic [cps_pkg::K_W-1:0]    k_q;

	// pipeline
	logic                               v_s1, first_s1, klast_s1, lv_s1;
	logic [cps_pkg::IDX_W-1:0]          pi_s1, pj_s1;
	logic signed [cps_pkg::COORD_W-1:0] rd_a_s1, rd_b_s1;
	logic                               v_s2, first_s2, klast_s2;
	logic [cps_pkg::IDX_W-1:0]          pi_s2, pj_s2;
	logic [cps_pkg::SQ_W-1:0]           sq_s2;
	logic [cps_pkg::DIST_W-1:0]         acc_q;
	logic                               pd_v_s3;
	logic [cps_pkg::IDX_W-1:0]          pi_s3, pj_s3;
	logic [cps_pkg::DIST_W-1:0]         pd_s3;

	// best pair and ordering
	logic                               best_v_q;
	logic [cps_pkg::DIST_W-1:0]         best_q;
	logic [cps_pkg::IDX_W-1:0]          best_a_q, best_b_q;
	logic [cps_pkg::ADDR_W-1:0]         best_ba_q, best_bb_q;
	logic                               dec_q, swap_q;

	logic                               dim_bad, k_last, j_last, i_last;
	logic [cps_pkg::ADDR_W-1:0]         addr_a, addr_b, dim_a;
	logic signed [cps_pkg::COORD_W:0]   diff;
	logic [cps_pkg::COORD_W-1:0]        absd;
	logic [cps_pkg::DIST_W-1:0]         acc_d;

	assign dim_a   = cps_pkg::ADDR_W'(dim_q);
	assign dim_bad = (dim_q == '0) || (32'(dim_q) > cps_pkg::MAX_DIM);
	assign k_last  = (cps_pkg::DIM_W'(k_q) == dim_q - cps_pkg::DIM_W'(1));
	assign j_last  = (cps_pkg::NP_W'(j_q) == np_q - cps_pkg::NP_W'(1));
	assign i_last  = (cps_pkg::NP_W'(i_q) == np_q - cps_pkg::NP_W'(2));

	assign sts.chk_bad    = ovf_q || dim_bad || (base_q > cps_pkg::BASE_W'(cnt_q)) ||
		(32'(np_q) > cps_pkg::MAX_POINTS);
	assign sts.chk_match  = (base_q == cps_pkg::BASE_W'(cnt_q));
	assign sts.chk_few    = (np_q < cps_pkg::NP_W'(2));
	assign sts.scan_final = k_last && j_last && i_last;
	assign sts.k_last     = k_last;
	assign sts.pipe_busy  = v_s1 || v_s2 || pd_v_s3 || lv_s1;
	assign sts.out_free   = !out_valid || !out_stall;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= cps_pkg::DIM_W'(2);
		end else if (cfg_we) begin
			dim_q <= cfg_data;
		end
	end

	// load and point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			if (32'(cnt_q) < cps_pkg::DEPTH) begin
				cnt_q <= cnt_q + cps_pkg::CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (32'(cnt_q) < cps_pkg::DEPTH)) begin
			mem[cnt_q[cps_pkg::ADDR_W-1:0]] <= coord;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.chk_init) begin
			base_q <= '0;
			np_q   <= '0;
		end else if (cmd.chk_step) begin
			base_q <= base_q + cps_pkg::BASE_W'(dim_q);
			np_q   <= np_q + cps_pkg::NP_W'(1);
		end
	end

	// pair scan sequencer
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			i_q  <= '0;
			j_q  <= cps_pkg::IDX_W'(1);
			bi_q <= '0;
			bj_q <= dim_a;
			k_q  <= '0;
		end else if (cmd.lex_init) begin
			k_q <= '0;
		end else if (cmd.scan_step) begin
			if (k_last) begin
				k_q <= '0;
				if (j_last) begin
					i_q  <= i_q + cps_pkg::IDX_W'(1);
					j_q  <= i_q + cps_pkg::IDX_W'(2);
					bi_q <= bi_q + dim_a;
					bj_q <= bi_q + dim_a + dim_a;
				end else begin
					j_q  <= j_q + cps_pkg::IDX_W'(1);
					bj_q <= bj_q + dim_a;
				end
			end else begin
				k_q <= k_q + cps_pkg::K_W'(1);
			end
		end else if (cmd.lex_step) begin
			k_q <= k_q + cps_pkg::K_W'(1);
		end
	end

	assign addr_a = (cmd.lex_step ? best_ba_q : bi_q) + cps_pkg::ADDR_W'(k_q);
	assign addr_b = (cmd.lex_step ? best_bb_q : bj_q) + cps_pkg::ADDR_W'(k_q);

	// stage 1: store read
	always_ff @(posedge clk) begin
		rd_a_s1  <= mem[addr_a];
		rd_b_s1  <= mem[addr_b];
		first_s1 <= (k_q == '0);
		klast_s1 <= k_last;
		pi_s1    <= i_q;
		pj_s1    <= j_q;
	end

	// stage 2: difference and square
	assign diff = {rd_a_s1[cps_pkg::COORD_W-1], rd_a_s1} - {rd_b_s1[cps_pkg::COORD_W-1], rd_b_s1};
	assign absd = diff[cps_pkg::COORD_W] ? cps_pkg::COORD_W'(-diff) : diff[cps_pkg::COORD_W-1:0];

	always_ff @(posedge clk) begin
		sq_s2    <= absd * absd;
		first_s2 <= first_s1;
		klast_s2 <= klast_s1;
		pi_s2    <= pi_s1;
		pj_s2    <= pj_s1;
	end

	// stage 3: accumulate over coordinates
	assign acc_d = (first_s2 ? '0 : acc_q) + cps_pkg::DIST_W'(sq_s2);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= acc_d;
		end
		pd_s3 <= acc_d;
		pi_s3 <= pi_s2;
		pj_s3 <= pj_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			lv_s1   <= 1'b0;
			v_s2    <= 1'b0;
			pd_v_s3 <= 1'b0;
		end else begin
			v_s1    <= cmd.scan_step;
			lv_s1   <= cmd.lex_step;
			v_s2    <= v_s1;
			pd_v_s3 <= v_s2 && klast_s2;
		end
	end

	// best pair, later pair wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_v_q <= 1'b0;
		end else if (cmd.scan_init) begin
			best_v_q <= 1'b0;
		end else if (pd_v_s3) begin
			best_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pd_v_s3 && (!best_v_q || (pd_s3 <= best_q))) begin
			best_q    <= pd_s3;
			best_a_q  <= pi_s3;
			best_b_q  <= pj_s3;
			best_ba_q <= cps_pkg::ADDR_W'(pi_s3) * cps_pkg::ADDR_W'(dim_q);
			best_bb_q <= cps_pkg::ADDR_W'(pj_s3) * cps_pkg::ADDR_W'(dim_q);
		end
	end

	// lexicographic order of the chosen pair
	always_ff @(posedge clk) begin
		if (cmd.lex_init) begin
			dec_q  <= 1'b0;
			swap_q <= 1'b0;
		end else if (lv_s1 && !dec_q) begin
			if (rd_b_s1 < rd_a_s1) begin
				dec_q  <= 1'b1;
				swap_q <= 1'b1;
			end else if (rd_a_s1 < rd_b_s1) begin
				dec_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.res_load || cmd.res_err) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_err) begin
			first_index  <= '0;
			second_index <= '0;
			min_distance <= '0;
			error        <= 1'b1;
		end else if (cmd.res_load) begin
			first_index  <= 6'(swap_q ? best_b_q : best_a_q);
			second_index <= 6'(swap_q ? best_a_q : best_b_q);
			min_distance <= best_q;
			error        <= 1'b0;
		end
	end

endmodule
